[hw/rtl/flrq_pkg.sv]
// Shared codes and field widths of the four-level ready queue.
`default_nettype none
package flrq_pkg;
  localparam int OpW     = 2;
  localparam int TidW    = 8;
  localparam int PrioW   = 2;
  localparam int StatW   = 2;
  localparam int OccW    = 6;

  localparam logic [OpW-1:0] OP_PUT    = 2'd0;
  localparam logic [OpW-1:0] OP_POP    = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd2;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY    = 2'd1;
  localparam logic [StatW-1:0] ST_FULL     = 2'd2;
  localparam logic [StatW-1:0] ST_NOTFOUND = 2'd3;
endpackage
`default_nettype wire

[hw/rtl/four_level_ready_queue.sv]
// Top level of the multilevel priority ready queue.
//
// Entries live in one RAM in arrival order; slots below the count are valid.
// A put writes one slot as it is taken and hands its result to the done state.
// Pop and remove scan all queued entries one RAM read a cycle, noting the
// oldest candidate per level. When something is taken out, a compaction pass
// follows that reads every slot again and writes the survivors down. The
// RAM's single read port paces both passes. The next item can be taken in
// the same cycle that the result shows. One item is worked on at a time; a
// finished result waits in the output register while the next item is taken.
`default_nettype none
module four_level_ready_queue
  import flrq_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int LEVELS   = 4,
  parameter int ID_BITS  = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,    // idle_thread_id
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // thread_id[7:0], priority_req[9:8]
  input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // result_id[7:0], occupancy[13:8]
  output logic      [1:0]  m_axis_tuser    // status[1:0]
);
  localparam int AddrW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int LvlW  = $clog2(LEVELS);
  localparam int WordW = LvlW + ID_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMPACT, S_DONE} state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   rd_ptr_q;
  logic [AddrW-1:0]  ra_q;
  logic [AddrW-1:0]  wr_ptr_q;
  logic              rv_q;
  logic [OpW-1:0]    op_q;
  logic [ID_BITS-1:0] key_q;
  logic [7:0]        idle_id_q;
  logic [LEVELS-1:0] found_q;
  logic [LEVELS-1:0] mark_q;
  logic [AddrW-1:0]  pos_q [LEVELS];
  logic [ID_BITS-1:0] fid_q [LEVELS];
  logic [7:0]        res_id_q;
  logic [StatW-1:0]  res_st_q;
  logic              m_valid_q;
  logic [15:0]       m_data_q;
  logic [1:0]        m_user_q;

  logic              accept;
  logic [ID_BITS+7:0] in_id_ext;
  logic [ID_BITS-1:0] in_id;
  logic [LvlW-1:0]   in_lvl;
  logic              rd_en;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [WordW-1:0]  wdata;
  logic [WordW-1:0]  rdata;
  logic [LvlW-1:0]   r_lvl;
  logic [ID_BITS-1:0] r_id;
  logic              removed;
  logic              pass_end;
  logic [LvlW-1:0]   top_lvl;
  logic [CntW-1:0]   n_rem;
  logic [ID_BITS+7:0] top_id_ext;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign in_id_ext = {{ID_BITS{1'b0}}, s_axis_tdata[7:0]};
  assign in_id     = in_id_ext[ID_BITS-1:0];
  assign r_lvl     = rdata[WordW-1:ID_BITS];
  assign r_id      = rdata[ID_BITS-1:0];
  assign pass_end  = (rd_ptr_q == count_q) && !rv_q;
  assign rd_en     = (state_q == S_SCAN || state_q == S_COMPACT) && (rd_ptr_q < count_q);

  always_comb begin
    if (int'(s_axis_tdata[9:8]) > LEVELS - 1) begin
      in_lvl = LvlW'(LEVELS - 1);
    end else begin
      in_lvl = LvlW'(s_axis_tdata[9:8]);
    end
  end

  always_comb begin
    removed = 1'b0;
    n_rem   = '0;
    top_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (mark_q[l] && pos_q[l] == ra_q) removed = 1'b1;
      n_rem = n_rem + CntW'(mark_q[l]);
      if (found_q[l]) top_lvl = LvlW'(l);
    end
    top_id_ext = {8'b0, fid_q[top_lvl]};
  end

  always_comb begin
    we    = 1'b0;
    waddr = wr_ptr_q;
    wdata = rdata;
    if (state_q == S_IDLE && accept && s_axis_tuser == OP_PUT &&
        count_q < CntW'(CAPACITY)) begin
      we    = 1'b1;
      waddr = count_q[AddrW-1:0];
      wdata = {in_lvl, in_id};
    end else if (state_q == S_COMPACT && rv_q && !removed) begin
      we = 1'b1;
    end
  end

  flrq_ram #(.Width(WordW), .Depth(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      ra_q      <= '0;
      wr_ptr_q  <= '0;
      rv_q      <= 1'b0;
      op_q      <= OP_PUT;
      key_q     <= '0;
      idle_id_q <= 8'd1;
      found_q   <= '0;
      mark_q    <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        pos_q[l] <= '0;
        fid_q[l] <= '0;
      end
      res_id_q  <= '0;
      res_st_q  <= ST_OK;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      if (cfg_we_i) idle_id_q <= cfg_wdata_i;
      if (m_valid_q && m_axis_tready && state_q != S_DONE) m_valid_q <= 1'b0;
      rv_q <= rd_en;
      if (rd_en) begin
        ra_q     <= rd_ptr_q[AddrW-1:0];
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= s_axis_tuser;
            key_q    <= in_id;
            rd_ptr_q <= '0;
            wr_ptr_q <= '0;
            found_q  <= '0;
            mark_q   <= '0;
            res_id_q <= '0;
            if (s_axis_tuser == OP_POP || s_axis_tuser == OP_REMOVE) begin
              res_st_q <= ST_OK;
              state_q  <= S_SCAN;
            end else begin
              state_q <= S_DONE;
              if (s_axis_tuser == OP_PUT && count_q >= CntW'(CAPACITY)) begin
                res_st_q <= ST_FULL;
              end else begin
                res_st_q <= ST_OK;
              end
              if (s_axis_tuser == OP_PUT && count_q < CntW'(CAPACITY)) begin
                count_q <= count_q + 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          if (rv_q && !found_q[r_lvl] && (op_q == OP_POP || r_id == key_q)) begin
            found_q[r_lvl] <= 1'b1;
            pos_q[r_lvl]   <= ra_q;
            fid_q[r_lvl]   <= r_id;
          end
          if (pass_end) begin
            rd_ptr_q <= '0;
            if (found_q == '0) begin
              state_q <= S_DONE;
              if (op_q == OP_POP) begin
                res_id_q <= idle_id_q;
                res_st_q <= ST_EMPTY;
              end else begin
                res_st_q <= ST_NOTFOUND;
              end
            end else begin
              state_q <= S_COMPACT;
              // mark_q was cleared when the item was taken
              if (op_q == OP_POP) begin
                mark_q[top_lvl] <= 1'b1;
                res_id_q        <= top_id_ext[7:0];
              end else begin
                mark_q <= found_q;
              end
            end
          end
        end
        S_COMPACT: begin
          if (rv_q && !removed) wr_ptr_q <= wr_ptr_q + 1'b1;
          if (pass_end) begin
            count_q <= count_q - n_rem;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {2'b00, OccW'(count_q), res_id_q};
            m_user_q  <= res_st_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/flrq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module flrq_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/flrq_checker.sv]
// Port-level checks for the ready queue, bound to the top level.
`default_nettype none
module flrq_checker
  import flrq_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  // one item at a time: taking an item closes the input side
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_FULL |->
      m_axis_tdata[13:8] == 6'(CAPACITY) && m_axis_tdata[7:0] == 8'd0)
    else $error("full status with wrong occupancy or id");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[13:8] == 6'd0)
    else $error("empty status with nonzero occupancy");
endmodule

bind four_level_ready_queue flrq_checker #(.CAPACITY(CAPACITY)) u_flrq_checker (.*);
`default_nettype wire

[tb/sv/flrq_checker.sv]
// Checker for the ready queue: predicts each result from accepted items and compares.
`default_nettype none
module flrq_scoreboard
  import flrq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser,
  output int               fail_count_o,
  output int               pending_o
);
  localparam int Cap = 32;

  typedef logic bool_t;

  typedef struct packed {
    logic [TidW-1:0]  rid;
    logic [StatW-1:0] stat;
    logic [OccW-1:0]  occ;
  } sched_res_t;

  logic [TidW-1:0]  idle_id;
  logic [TidW-1:0]  q_id  [Cap];
  logic [PrioW-1:0] q_lvl [Cap];
  int               q_cnt;
  sched_res_t       expected_q[$];

  function automatic void drop_entry(input int pos);
    for (int k = pos; k + 1 < q_cnt; k++) begin
      q_id[k]  = q_id[k+1];
      q_lvl[k] = q_lvl[k+1];
    end
    q_cnt--;
  endfunction

  function automatic sched_res_t schedule_op(input logic [OpW-1:0] op,
                                             input logic [TidW-1:0] tid,
                                             input logic [PrioW-1:0] lvl);
    sched_res_t r;
    bool_t found;
    r = '0;
    found = 1'b0;
    case (op)
      OP_PUT: begin
        if (q_cnt >= Cap) r.stat = ST_FULL;
        else begin
          q_id[q_cnt]  = tid;
          q_lvl[q_cnt] = lvl;
          q_cnt++;
        end
      end
      OP_POP: begin
        for (int l = 3; l >= 0 && !found; l--)
          for (int k = 0; k < q_cnt && !found; k++)
            if (q_lvl[k] == l) begin
              r.rid = q_id[k];
              drop_entry(k);
              found = 1'b1;
            end
        if (!found) begin
          r.rid  = idle_id;
          r.stat = ST_EMPTY;
        end
      end
      OP_REMOVE: begin
        for (int l = 0; l < 4; l++) begin
          bool_t hit;
          hit = 1'b0;
          for (int k = 0; k < q_cnt && !hit; k++)
            if (q_lvl[k] == l && q_id[k] == tid) begin
              drop_entry(k);
              hit = 1'b1;
              found = 1'b1;
            end
        end
        if (!found) r.stat = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.occ = q_cnt[OccW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t got, exp_r;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      idle_id = 8'd1;
      q_cnt   = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) idle_id = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(schedule_op(s_axis_tuser, s_axis_tdata[7:0],
                                         s_axis_tdata[9:8]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.rid  = m_axis_tdata[7:0];
        got.occ  = m_axis_tdata[13:8];
        got.stat = m_axis_tuser;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %h", got);
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.rid !== exp_r.rid) begin
            $error("result_id expected %0d got %0d", exp_r.rid, got.rid);
            errs++;
          end
          if (got.stat !== exp_r.stat) begin
            $error("status expected %0d got %0d", exp_r.stat, got.stat);
            errs++;
          end
          if (got.occ !== exp_r.occ) begin
            $error("occupancy expected %0d got %0d", exp_r.occ, got.occ);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_q.size();
    end
  end
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench top for the ready queue: stimulus, idling and verdict.
`default_nettype none
module tb;
  import flrq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  int          cycle_cnt = 0;
  logic        calm = 1'b0;
  logic [7:0]  sent_ids[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  four_level_ready_queue u_dut (.*);

  flrq_scoreboard u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata, .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 2_000_000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls in bursts unless calm is set
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [OpW-1:0] op, input logic [7:0] tid,
                           input logic [1:0] prio);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, prio, tid};
    if (op == OP_PUT) sent_ids.push_back(tid);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    // let the count of the last accepted item settle first
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_idle(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_item();
    int sel;
    logic [7:0] tid;
    sel = $urandom_range(0, 99);
    if (sent_ids.size() != 0 && $urandom_range(0, 3) != 0)
      tid = sent_ids[$urandom_range(0, sent_ids.size() - 1)];
    else
      tid = 8'($urandom_range(0, 255));
    if (sel < 45)      send_item(OP_PUT, tid, 2'($urandom_range(0, 3)));
    else if (sel < 75) send_item(OP_POP, 8'($urandom_range(0, 255)),
                                 2'($urandom_range(0, 3)));
    else if (sel < 97) send_item(OP_REMOVE, tid, 2'($urandom_range(0, 3)));
    else               send_item(2'd3, 8'($urandom_range(0, 255)),
                                 2'($urandom_range(0, 3)));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty pop with reset idle id, extremes, duplicates, absent id
    send_item(OP_POP, 8'hFF, 2'd3);
    send_item(OP_REMOVE, 8'h00, 2'd0);
    send_item(OP_PUT, 8'h00, 2'd0);
    send_item(OP_PUT, 8'hFF, 2'd3);
    send_item(OP_PUT, 8'h55, 2'd1);
    send_item(OP_PUT, 8'h55, 2'd1);
    send_item(OP_PUT, 8'h55, 2'd2);
    send_item(OP_PUT, 8'hAA, 2'd2);
    send_item(OP_REMOVE, 8'h55, 2'd0);
    send_item(OP_REMOVE, 8'h77, 2'd0);
    send_item(2'd3, 8'hFF, 2'd3);
    repeat (6) send_item(OP_POP, 8'h00, 2'd0);
    quiesce();
    write_idle(8'hFF);
    // fill past capacity: the last puts are dropped
    for (int i = 0; i < 34; i++) send_item(OP_PUT, i[7:0], i[1:0]);
    quiesce();
    write_idle(8'h00);
    for (int i = 0; i < 36; i++) send_item(OP_POP, 8'h00, 2'd0);
    quiesce();
    for (int ph = 0; ph < 4; ph++) begin
      write_idle(ph == 3 ? 8'h80 : 8'($urandom_range(0, 255)));
      if (ph == 3) calm = 1'b1;
      for (int i = 0; i < 380; i++) random_item();
      quiesce();
    end
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
